// ===== rtl/core/kta_pkg.sv =====
`default_nettype none

package kta_pkg;

   localparam int KeyCodeWidth  = 8;
   localparam int KeyValueWidth = 2;
   localparam int CharWidth     = 7;
   localparam int TableSize     = 58;
   localparam int TableIdxWidth = $clog2(TableSize);

   localparam logic [KeyCodeWidth-1:0] KEY_LSHIFT = 8'd42;
   localparam logic [KeyCodeWidth-1:0] KEY_RSHIFT = 8'd54;
   localparam logic [KeyCodeWidth-1:0] KEY_LCTRL  = 8'd29;
   localparam logic [KeyCodeWidth-1:0] KEY_RCTRL  = 8'd97;
   localparam logic [KeyCodeWidth-1:0] KEY_LALT   = 8'd56;
   localparam logic [KeyCodeWidth-1:0] KEY_RALT   = 8'd100;
   localparam logic [KeyCodeWidth-1:0] KEY_CAPS   = 8'd58;
   localparam logic [KeyCodeWidth-1:0] KEY_T      = 8'd20;
   localparam logic [KeyCodeWidth-1:0] KEY_Q      = 8'd16;

   localparam logic [KeyValueWidth-1:0] KEY_VALUE_RELEASE = 2'd0;
   localparam logic [KeyValueWidth-1:0] KEY_VALUE_PRESS   = 2'd1;

   localparam logic [CharWidth-1:0] CASE_BIT  = 7'h20;
   localparam logic [CharWidth-1:0] CTRL_MASK = 7'h1f;
   localparam logic [CharWidth-1:0] CHAR_NONE = 7'h00;

   typedef enum logic [1:0] {
      HOTKEY_NONE     = 2'd0,
      HOTKEY_TERMINAL = 2'd1,
      HOTKEY_QUIT     = 2'd2
   } hotkey_type;

   function automatic logic is_letter(input logic [CharWidth-1:0] c);
      return ((c >= 7'h61) && (c <= 7'h7a)) || ((c >= 7'h41) && (c <= 7'h5a));
   endfunction

   function automatic logic [CharWidth-1:0] plain_char(input logic [TableIdxWidth-1:0] idx);
      logic [CharWidth-1:0] c;
      case (idx)
         6'd1:  c = 7'h1b;
         6'd2:  c = 7'h31;
         6'd3:  c = 7'h32;
         6'd4:  c = 7'h33;
         6'd5:  c = 7'h34;
         6'd6:  c = 7'h35;
         6'd7:  c = 7'h36;
         6'd8:  c = 7'h37;
         6'd9:  c = 7'h38;
         6'd10: c = 7'h39;
         6'd11: c = 7'h30;
         6'd12: c = 7'h2d;
         6'd13: c = 7'h3d;
         6'd14: c = 7'h08;
         6'd15: c = 7'h09;
         6'd16: c = 7'h71;
         6'd17: c = 7'h77;
         6'd18: c = 7'h65;
         6'd19: c = 7'h72;
         6'd20: c = 7'h74;
         6'd21: c = 7'h79;
         6'd22: c = 7'h75;
         6'd23: c = 7'h69;
         6'd24: c = 7'h6f;
         6'd25: c = 7'h70;
         6'd26: c = 7'h5b;
         6'd27: c = 7'h5d;
         6'd28: c = 7'h0a;
         6'd30: c = 7'h61;
         6'd31: c = 7'h73;
         6'd32: c = 7'h64;
         6'd33: c = 7'h66;
         6'd34: c = 7'h67;
         6'd35: c = 7'h68;
         6'd36: c = 7'h6a;
         6'd37: c = 7'h6b;
         6'd38: c = 7'h6c;
         6'd39: c = 7'h3b;
         6'd40: c = 7'h27;
         6'd41: c = 7'h60;
         6'd43: c = 7'h5c;
         6'd44: c = 7'h7a;
         6'd45: c = 7'h78;
         6'd46: c = 7'h63;
         6'd47: c = 7'h76;
         6'd48: c = 7'h62;
         6'd49: c = 7'h6e;
         6'd50: c = 7'h6d;
         6'd51: c = 7'h2c;
         6'd52: c = 7'h2e;
         6'd53: c = 7'h2f;
         6'd55: c = 7'h2a;
         6'd57: c = 7'h20;
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [CharWidth-1:0] shifted_char(input logic [TableIdxWidth-1:0] idx);
      logic [CharWidth-1:0] p;
      logic [CharWidth-1:0] c;
      p = plain_char(idx);
      case (idx)
         6'd2:  c = 7'h21;
         6'd3:  c = 7'h40;
         6'd4:  c = 7'h23;
         6'd5:  c = 7'h24;
         6'd6:  c = 7'h25;
         6'd7:  c = 7'h5e;
         6'd8:  c = 7'h26;
         6'd9:  c = 7'h2a;
         6'd10: c = 7'h28;
         6'd11: c = 7'h29;
         6'd12: c = 7'h5f;
         6'd13: c = 7'h2b;
         6'd26: c = 7'h7b;
         6'd27: c = 7'h7d;
         6'd39: c = 7'h3a;
         6'd40: c = 7'h22;
         6'd41: c = 7'h7e;
         6'd43: c = 7'h7c;
         6'd51: c = 7'h3c;
         6'd52: c = 7'h3e;
         6'd53: c = 7'h3f;
         default: c = is_letter(p) ? (p ^ CASE_BIT) : p;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/keycode_to_ascii_translator.sv =====
// Translates key events (Linux key code plus release, press or autorepeat value) into one
// result item each: a forward flag, the typed ASCII character under a US layout and a hotkey
// code. Shift, ctrl, alt and caps lock are tracked internally; modifier events are consumed,
// and ctrl+alt presses of T and Q report the terminal and quit hotkeys. An item is accepted
// every cycle unless backpressure has filled both registers: the item waits in the input
// register, and the table lookup and modifier update load the result register once it is
// free. The result register holds under backpressure while the input register still takes
// one more item.
`default_nettype none

module keycode_to_ascii_translator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [kta_pkg::KeyCodeWidth-1:0]    req_key_code,
   input  wire logic [kta_pkg::KeyValueWidth-1:0]   req_key_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_forward,
   output logic [kta_pkg::CharWidth-1:0]            rsp_character,
   output logic [1:0]                               rsp_hotkey
);

   logic                                   in_valid_ff;
   logic [kta_pkg::KeyCodeWidth-1:0]       key_code_ff;
   logic [kta_pkg::KeyValueWidth-1:0]      key_value_ff;

   logic                                   out_valid_ff;
   logic                                   forward_ff;
   logic                                   forward_in;
   logic [kta_pkg::CharWidth-1:0]          character_ff;
   logic [kta_pkg::CharWidth-1:0]          character_in;
   kta_pkg::hotkey_type                    hotkey_ff;
   kta_pkg::hotkey_type                    hotkey_in;

   logic                                   shift_ff, shift_in;
   logic                                   ctrl_ff, ctrl_in;
   logic                                   alt_ff, alt_in;
   logic                                   caps_ff, caps_in;

   logic                                   out_free;
   logic                                   advance;
   logic                                   down;
   logic                                   is_press;
   logic                                   is_shift, is_ctrl, is_alt, is_caps;
   logic [kta_pkg::TableIdxWidth-1:0]      table_idx;
   logic [kta_pkg::CharWidth-1:0]          base_char;
   logic [kta_pkg::CharWidth-1:0]          case_char;
   logic [kta_pkg::CharWidth-1:0]          typed_char;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign down     = (key_value_ff != kta_pkg::KEY_VALUE_RELEASE);
   assign is_press = (key_value_ff == kta_pkg::KEY_VALUE_PRESS);
   assign is_shift = (key_code_ff == kta_pkg::KEY_LSHIFT) || (key_code_ff == kta_pkg::KEY_RSHIFT);
   assign is_ctrl  = (key_code_ff == kta_pkg::KEY_LCTRL) || (key_code_ff == kta_pkg::KEY_RCTRL);
   assign is_alt   = (key_code_ff == kta_pkg::KEY_LALT) || (key_code_ff == kta_pkg::KEY_RALT);
   assign is_caps  = (key_code_ff == kta_pkg::KEY_CAPS);

   assign table_idx = key_code_ff[kta_pkg::TableIdxWidth-1:0];

   always_comb begin
      if (key_code_ff >= kta_pkg::KeyCodeWidth'(kta_pkg::TableSize)) begin
         base_char = kta_pkg::CHAR_NONE;
      end else if (shift_ff) begin
         base_char = kta_pkg::shifted_char(table_idx);
      end else begin
         base_char = kta_pkg::plain_char(table_idx);
      end
      case_char  = (caps_ff && kta_pkg::is_letter(base_char)) ? (base_char ^ kta_pkg::CASE_BIT)
                                                              : base_char;
      typed_char = (ctrl_ff && kta_pkg::is_letter(case_char)) ? (case_char & kta_pkg::CTRL_MASK)
                                                              : case_char;
   end

   always_comb begin
      shift_in     = shift_ff;
      ctrl_in      = ctrl_ff;
      alt_in       = alt_ff;
      caps_in      = caps_ff;
      forward_in   = 1'b0;
      character_in = kta_pkg::CHAR_NONE;
      hotkey_in    = kta_pkg::HOTKEY_NONE;
      if (is_shift) begin
         shift_in = down;
      end else if (is_ctrl) begin
         ctrl_in = down;
      end else if (is_alt) begin
         alt_in = down;
      end else if (is_caps) begin
         caps_in = caps_ff ^ is_press;
      end else if (ctrl_ff && alt_ff && is_press && (key_code_ff == kta_pkg::KEY_T)) begin
         hotkey_in = kta_pkg::HOTKEY_TERMINAL;
      end else if (ctrl_ff && alt_ff && is_press && (key_code_ff == kta_pkg::KEY_Q)) begin
         hotkey_in = kta_pkg::HOTKEY_QUIT;
      end else begin
         forward_in   = 1'b1;
         character_in = down ? typed_char : kta_pkg::CHAR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         alt_ff       <= 1'b0;
         caps_ff      <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            shift_ff <= shift_in;
            ctrl_ff  <= ctrl_in;
            alt_ff   <= alt_in;
            caps_ff  <= caps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         key_code_ff  <= req_key_code;
         key_value_ff <= req_key_value;
      end
      if (advance) begin
         forward_ff   <= forward_in;
         character_ff <= character_in;
         hotkey_ff    <= hotkey_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_forward   = forward_ff;
   assign rsp_character = character_ff;
   assign rsp_hotkey    = hotkey_ff;

endmodule

`default_nettype wire

// ===== rtl/core/kta_checker.sv =====
`default_nettype none

module kta_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_forward,
   input wire logic [kta_pkg::CharWidth-1:0]     rsp_character,
   input wire logic [1:0]                        rsp_hotkey
);

   // A result that is waiting must hold its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_forward)
         && $stable(rsp_character) && $stable(rsp_hotkey))
      else $error("stalled result item changed");

   // Forwarded events never carry a hotkey.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forward |-> rsp_hotkey == kta_pkg::HOTKEY_NONE)
      else $error("forwarded item carries a hotkey");

   // Consumed events and hotkeys type no character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_forward |-> rsp_character == kta_pkg::CHAR_NONE)
      else $error("consumed item carries a character");

   // Nothing is presented right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item valid right after reset");

endmodule

bind keycode_to_ascii_translator kta_checker u_kta_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_forward   (rsp_forward),
   .rsp_character (rsp_character),
   .rsp_hotkey    (rsp_hotkey)
);

`default_nettype wire

// ===== tb/keycode_to_ascii_translator_tb.sv =====
module keycode_to_ascii_translator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kta_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned REPORT_LIMIT = 10;

   localparam logic [KeyValueWidth-1:0] VALUE_REPEAT = 2'd2;
   localparam logic [KeyValueWidth-1:0] VALUE_ODD    = 2'd3;

   localparam logic [KeyCodeWidth-1:0] KEY_NONE  = 8'd0;
   localparam logic [KeyCodeWidth-1:0] KEY_1     = 8'd2;
   localparam logic [KeyCodeWidth-1:0] KEY_A     = 8'd30;
   localparam logic [KeyCodeWidth-1:0] KEY_Z     = 8'd44;
   localparam logic [KeyCodeWidth-1:0] KEY_SPACE = 8'd57;
   localparam logic [KeyCodeWidth-1:0] KEY_F1    = 8'd59;
   localparam logic [KeyCodeWidth-1:0] KEY_HIGH  = 8'd128;
   localparam logic [KeyCodeWidth-1:0] KEY_MAX   = 8'd255;

   typedef struct packed {
      logic                 forward;
      logic [CharWidth-1:0] character;
      hotkey_type           hotkey;
   } key_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [KeyCodeWidth-1:0]  req_key_code;
   logic [KeyValueWidth-1:0] req_key_value;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_forward;
   logic [CharWidth-1:0]     rsp_character;
   logic [1:0]               rsp_hotkey;

   logic [CharWidth-1:0] plain_table [0:TableSize-1] = '{
      7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
      7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
      7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20
   };

   logic [CharWidth-1:0] shifted_table [0:TableSize-1] = '{
      7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
      7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
      7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
      7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20
   };

   logic [KeyCodeWidth-1:0] modifier_keys [0:6] = '{
      KEY_LSHIFT, KEY_RSHIFT, KEY_LCTRL, KEY_RCTRL, KEY_LALT, KEY_RALT, KEY_CAPS
   };

   bit shift_down = 1'b0;
   bit ctrl_down  = 1'b0;
   bit alt_down   = 1'b0;
   bit caps_on    = 1'b0;

   key_result_type expected_results [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;

   int unsigned hold_off_length = 0;
   int unsigned hold_off_id = 0;
   int unsigned hold_off_seen = 0;
   int unsigned hold_off_left = 0;

   keycode_to_ascii_translator u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_key_code  (req_key_code),
      .req_key_value (req_key_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_forward   (rsp_forward),
      .rsp_character (rsp_character),
      .rsp_hotkey    (rsp_hotkey)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit alpha_char(input logic [CharWidth-1:0] c);
      return (c >= 7'h61 && c <= 7'h7a) || (c >= 7'h41 && c <= 7'h5a);
   endfunction

   function automatic key_result_type translate_key_event(input logic [KeyCodeWidth-1:0] code,
                                                          input logic [KeyValueWidth-1:0] value);
      key_result_type res;
      logic [CharWidth-1:0] ch;
      bit held;
      res.forward = 1'b0;
      res.character = CHAR_NONE;
      res.hotkey = HOTKEY_NONE;
      held = (value != KEY_VALUE_RELEASE);
      if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
         shift_down = held;
      end else if (code == KEY_LCTRL || code == KEY_RCTRL) begin
         ctrl_down = held;
      end else if (code == KEY_LALT || code == KEY_RALT) begin
         alt_down = held;
      end else if (code == KEY_CAPS) begin
         if (value == KEY_VALUE_PRESS) begin
            caps_on = !caps_on;
         end
      end else if (ctrl_down && alt_down && value == KEY_VALUE_PRESS && code == KEY_T) begin
         res.hotkey = HOTKEY_TERMINAL;
      end else if (ctrl_down && alt_down && value == KEY_VALUE_PRESS && code == KEY_Q) begin
         res.hotkey = HOTKEY_QUIT;
      end else begin
         res.forward = 1'b1;
         if (held && code < TableSize) begin
            ch = shift_down ? shifted_table[code[TableIdxWidth-1:0]]
                            : plain_table[code[TableIdxWidth-1:0]];
            if (caps_on && alpha_char(ch)) begin
               ch = ch ^ CASE_BIT;
            end
            if (ctrl_down && alpha_char(ch)) begin
               ch = ch & CTRL_MASK;
            end
            res.character = ch;
         end
      end
      return res;
   endfunction

   task automatic record_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      key_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               record_mismatch($sformatf("unexpected result item fwd=%0d char=%h hotkey=%0d",
                                         rsp_forward, rsp_character, rsp_hotkey));
            end else begin
               want = expected_results.pop_front();
               if (rsp_forward !== want.forward || rsp_character !== want.character ||
                   rsp_hotkey !== want.hotkey) begin
                  record_mismatch($sformatf(
                     "expected fwd=%0d char=%h hotkey=%0d, got fwd=%0d char=%h hotkey=%0d",
                     want.forward, want.character, want.hotkey,
                     rsp_forward, rsp_character, rsp_hotkey));
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(translate_key_event(req_key_code, req_key_value));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off_id != hold_off_seen) begin
         hold_off_seen = hold_off_id;
         hold_off_left = hold_off_length;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_key(input logic [KeyCodeWidth-1:0] code,
                           input logic [KeyValueWidth-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_key_code <= code;
      req_key_value <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [KeyValueWidth-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 6) return KEY_VALUE_PRESS;
      if (r < 8) return KEY_VALUE_RELEASE;
      if (r < 9) return VALUE_REPEAT;
      return VALUE_ODD;
   endfunction

   function automatic logic [KeyCodeWidth-1:0] random_code(input int unsigned low,
                                                            input int unsigned high);
      return KeyCodeWidth'($urandom_range(low, high));
   endfunction

   function automatic logic [KeyValueWidth-1:0] random_value();
      return KeyValueWidth'($urandom_range(3));
   endfunction

   task automatic send_chord();
      int unsigned taps;
      bit with_shift;
      logic [KeyCodeWidth-1:0] target;
      with_shift = $urandom_range(3) == 0;
      send_key($urandom_range(1) ? KEY_LCTRL : KEY_RCTRL, KEY_VALUE_PRESS);
      send_key($urandom_range(1) ? KEY_LALT : KEY_RALT, KEY_VALUE_PRESS);
      if (with_shift) begin
         send_key(KEY_LSHIFT, KEY_VALUE_PRESS);
      end
      taps = $urandom_range(1, 3);
      repeat (taps) begin
         case ($urandom_range(3))
            0: target = KEY_T;
            1: target = KEY_Q;
            default: target = random_code(0, TableSize - 1);
         endcase
         send_key(target, pick_value());
      end
      if (with_shift) begin
         send_key(KEY_RSHIFT, KEY_VALUE_RELEASE);
      end
      send_key($urandom_range(1) ? KEY_LALT : KEY_RALT, KEY_VALUE_RELEASE);
      send_key($urandom_range(1) ? KEY_LCTRL : KEY_RCTRL, KEY_VALUE_RELEASE);
   endtask

   task automatic test_directed();
      send_key(KEY_NONE, KEY_VALUE_RELEASE);
      send_key(KEY_MAX, VALUE_ODD);
      send_key(KEY_A, KEY_VALUE_PRESS);
      send_key(KEY_LSHIFT, KEY_VALUE_PRESS);
      send_key(KEY_A, VALUE_REPEAT);
      send_key(KEY_1, KEY_VALUE_PRESS);
      send_key(KEY_RSHIFT, KEY_VALUE_RELEASE);
      send_key(KEY_CAPS, KEY_VALUE_PRESS);
      send_key(KEY_CAPS, VALUE_REPEAT);
      send_key(KEY_CAPS, VALUE_ODD);
      send_key(KEY_Z, KEY_VALUE_PRESS);
      send_key(KEY_LCTRL, VALUE_ODD);
      send_key(KEY_Z, KEY_VALUE_PRESS);
      send_key(KEY_RALT, KEY_VALUE_PRESS);
      send_key(KEY_T, KEY_VALUE_PRESS);
      send_key(KEY_Q, KEY_VALUE_PRESS);
      send_key(KEY_T, VALUE_REPEAT);
      send_key(KEY_Q, VALUE_ODD);
      send_key(KEY_T, KEY_VALUE_RELEASE);
      send_key(KEY_RCTRL, KEY_VALUE_RELEASE);
      send_key(KEY_LALT, KEY_VALUE_RELEASE);
      send_key(KEY_CAPS, KEY_VALUE_PRESS);
      send_key(KEY_SPACE, KEY_VALUE_PRESS);
      send_key(KEY_HIGH, KEY_VALUE_PRESS);
      send_key(KEY_F1, KEY_VALUE_PRESS);
      wait_for_results();
   endtask

   task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                              input int unsigned stall_pct);
      int unsigned goal;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      goal = items_sent + count;
      while (items_sent < goal) begin
         case ($urandom_range(9))
            0, 1, 2, 3: send_key(random_code(0, TableSize - 1), pick_value());
            4, 5: send_key(modifier_keys[3'($urandom_range(6))], random_value());
            6, 7: send_chord();
            8: send_key(random_code(0, 255), random_value());
            default: send_key(random_code(TableSize, 255), pick_value());
         endcase
      end
      wait_for_results();
   endtask

   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_length = 60;
      hold_off_id++;
      repeat (30) begin
         send_key(random_code(0, 255), random_value());
      end
      wait_for_results();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_key_code = '0;
      req_key_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(110, 0, 0);
      test_random(100, 78, 0);
      test_random(100, 0, 78);
      test_random(110, 35, 35);
      test_backpressure();

      if (expected_results.size() != 0) begin
         record_mismatch($sformatf("%0d result items never arrived", expected_results.size()));
      end
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/kta_pkg.sv
rtl/core/keycode_to_ascii_translator.sv
rtl/core/kta_checker.sv
tb/keycode_to_ascii_translator_tb.sv
